// File: rtl/glyr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glyr_pkg
// Shared types and constants for the glyph bitmap rasteriser.
// ----------------------------------------------------------------------------
package glyr_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned CoordW      = 8;
  localparam int unsigned ColorW      = 16;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned OutDataW    = 40;

  // rows above the glyph top taken off the line advance: one plus two
  localparam logic [CoordW-1:0] TopRowBias = 8'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOriginX     = 3'd0,
    CfgOriginY     = 3'd1,
    CfgGlyphWidth  = 3'd2,
    CfgGlyphHeight = 3'd3,
    CfgGlyphYOff   = 3'd4,
    CfgLineAdvance = 3'd5,
    CfgScale       = 3'd6,
    CfgPixelColor  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [CoordW-1:0] origin_x;
    logic [CoordW-1:0] origin_y;
    logic [CoordW-1:0] glyph_width;
    logic [CoordW-1:0] glyph_height;
    logic [CoordW-1:0] glyph_y_offset;
    logic [CoordW-1:0] line_advance;
    logic [CoordW-1:0] scale;
    logic [ColorW-1:0] pixel_color;
  } glyr_cfg_t;

  // per-bit source position of one bitmap byte, bit 0 is the byte's MSB
  typedef struct packed {
    logic [BitsPerByte-1:0]             mask;
    logic [BitsPerByte-1:0][CoordW-1:0] col;
    logic [BitsPerByte-1:0][CoordW-1:0] row;
  } byte_plan_t;

endpackage
`default_nettype wire

// File: rtl/glyr_bit_walker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glyr_bit_walker
// Walks the eight bits of one bitmap byte through the column and row
// counters and records which bits give a square and where.
// ----------------------------------------------------------------------------
module glyr_bit_walker
  import glyr_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   accept_i,
  input  wire logic [BitsPerByte-1:0] glyph_bits_i,
  input  wire logic                   glyph_start_i,
  input  wire logic [CoordW-1:0]      glyph_width_i,
  input  wire logic [CoordW-1:0]      glyph_height_i,
  output byte_plan_t                  plan_o
);

  logic [CoordW-1:0] col_q, col_d;
  logic [CoordW-1:0] row_q, row_d;

  always_comb begin
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic              active;
    logic              live;
    col    = glyph_start_i ? '0 : col_q;
    row    = glyph_start_i ? '0 : row_q;
    active = (glyph_width_i != '0) && (glyph_height_i != '0);
    plan_o = '0;
    for (int b = 0; b < BitsPerByte; b++) begin
      live          = active && (row < glyph_height_i);
      plan_o.mask[b] = live && glyph_bits_i[BitsPerByte-1-b];
      plan_o.col[b]  = col;
      plan_o.row[b]  = row;
      if (live) begin
        if (({1'b0, col} + 9'd1) >= {1'b0, glyph_width_i}) begin
          col = '0;
          row = row + 8'd1;
        end else begin
          col = col + 8'd1;
        end
      end
    end
    col_d = col;
    row_d = row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/glyr_square_emitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glyr_square_emitter
// Holds the plan of one byte and sends its squares one beat per cycle while
// the output is not stalled, scaling the source position into screen coordinates.
// ----------------------------------------------------------------------------
module glyr_square_emitter
  import glyr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  byte_plan_t               plan_i,
  input  glyr_cfg_t                cfg_i,
  output logic                     can_load_o,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [7:0] square_x, [15:8] square_y, [23:16] square_size, [39:24] square_color
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tlast
);

  logic [BitsPerByte-1:0]             mask_q, mask_d;
  logic [BitsPerByte-1:0][CoordW-1:0] col_q;
  logic [BitsPerByte-1:0][CoordW-1:0] row_q;

  logic                   out_valid_q;
  logic [OutDataW-1:0]    out_data_q, out_data_d;
  logic                   out_last_q;

  logic [BitsPerByte-1:0] pick;
  logic [BitsPerByte-1:0] rest;
  logic [CoordW-1:0]      sel_col, sel_row;
  logic [CoordW-1:0]      y_base, y_steps;
  logic [2*CoordW-1:0]    prod_x, prod_y;
  logic [CoordW-1:0]      sq_x, sq_y;
  logic                   advance;

  always_comb begin
    logic found;
    found   = 1'b0;
    pick    = '0;
    sel_col = '0;
    sel_row = '0;
    for (int b = 0; b < BitsPerByte; b++) begin
      if (mask_q[b] && !found) begin
        found   = 1'b1;
        pick[b] = 1'b1;
        sel_col = col_q[b];
        sel_row = row_q[b];
      end
    end
  end

  assign rest    = mask_q & ~pick;
  assign advance = (mask_q != '0) && (!out_valid_q || m_axis_tready);
  assign can_load_o = (mask_q == '0) || (advance && (rest == '0));

  // y = origin_y + scale * (line_advance - 3 + y_offset + row), modulo 256
  assign y_base  = cfg_i.line_advance - TopRowBias + cfg_i.glyph_y_offset;
  assign y_steps = y_base + sel_row;
  assign prod_x  = {{CoordW{1'b0}}, cfg_i.scale} * {{CoordW{1'b0}}, sel_col};
  assign prod_y  = {{CoordW{1'b0}}, cfg_i.scale} * {{CoordW{1'b0}}, y_steps};
  assign sq_x    = cfg_i.origin_x + prod_x[CoordW-1:0];
  assign sq_y    = cfg_i.origin_y + prod_y[CoordW-1:0];

  assign out_data_d = {cfg_i.pixel_color, cfg_i.scale, sq_y, sq_x};

  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      mask_d = plan_i.mask;
    end else if (advance) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      col_q <= plan_i.col;
      row_q <= plan_i.row;
    end
    if (advance) begin
      out_data_q <= out_data_d;
      out_last_q <= (rest == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ((mask_q == '0) || (advance && (rest == '0))))
    else $error("plan loaded over pending squares");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("square lost on the way to the output register");

  a_one_square_per_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !load_i) |=>
      ($countones(mask_q) + 1 == $countones($past(mask_q))))
    else $error("buffer did not drop exactly one square");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (rest == '0) && !load_i) |=> (mask_q == '0))
    else $error("squares left after last of byte");

endmodule
`default_nettype wire

// File: rtl/glyph_bitmap_rasterizer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_bitmap_rasterizer_core
// Expands packed 1-bit glyph bitmap bytes into scaled pixel squares.
//
//   channel  dir  beat                                   accepted when
//   s_axis   in   tdata[7:0] bitmap byte, tuser start    tvalid & tready
//   m_axis   out  tdata x/y/size/colour, tlast last sq.  tvalid & tready
//   cfg      in   index 0..7, data (8 or 16 bits used)   cfg_valid_i & cfg_ready_o
//
// One square per cycle while m_axis is not stalled; a byte holds the emitter
// until its last square (of at most 8) leaves, a byte with none leaves it free.
// The next byte is taken in the cycle its predecessor's last square leaves
// the buffer. Output is a registered stage; a stall holds the beat and
// back-pressures s_axis once the byte buffer is full. Reset clears the
// counters, buffer and output valid; registers reset to 0, scale to 1.
// ----------------------------------------------------------------------------
module glyph_bitmap_rasterizer_core
  import glyr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [7:0] glyph_bits
  input  wire logic [BitsPerByte-1:0] s_axis_tdata,
  // [0] glyph_start
  input  wire logic                s_axis_tuser,

  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [7:0] square_x, [15:8] square_y, [23:16] square_size, [39:24] square_color
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tlast,

  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  glyr_cfg_t  cfg_q;
  byte_plan_t plan;
  logic       can_load;
  logic       accept;
  cfg_reg_e   cfg_sel;

  assign cfg_ready_o   = 1'b1;
  assign cfg_sel       = cfg_reg_e'(cfg_index_i);
  assign s_axis_tready = can_load;
  assign accept        = s_axis_tvalid && can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{scale: 8'd1, default: '0};
    end else if (cfg_valid_i) begin
      unique case (cfg_sel)
        CfgOriginX:     cfg_q.origin_x       <= cfg_data_i[CoordW-1:0];
        CfgOriginY:     cfg_q.origin_y       <= cfg_data_i[CoordW-1:0];
        CfgGlyphWidth:  cfg_q.glyph_width    <= cfg_data_i[CoordW-1:0];
        CfgGlyphHeight: cfg_q.glyph_height   <= cfg_data_i[CoordW-1:0];
        CfgGlyphYOff:   cfg_q.glyph_y_offset <= cfg_data_i[CoordW-1:0];
        CfgLineAdvance: cfg_q.line_advance   <= cfg_data_i[CoordW-1:0];
        CfgScale:       cfg_q.scale          <= cfg_data_i[CoordW-1:0];
        CfgPixelColor:  cfg_q.pixel_color    <= cfg_data_i[ColorW-1:0];
        default:        cfg_q.pixel_color    <= cfg_q.pixel_color;
      endcase
    end
  end

  glyr_bit_walker u_walker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .glyph_bits_i   (s_axis_tdata),
    .glyph_start_i  (s_axis_tuser),
    .glyph_width_i  (cfg_q.glyph_width),
    .glyph_height_i (cfg_q.glyph_height),
    .plan_o         (plan)
  );

  glyr_square_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .plan_i        (plan),
    .cfg_i         (cfg_q),
    .can_load_o    (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// File: test/glyph_raster_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_raster_checker
// Watches the bitmap, square and register channels of the glyph rasteriser.
// Keeps its own copy of the glyph registers and column/row counters, works
// out the squares that each accepted bitmap beat should give, and compares
// every square beat field by field with the oldest one still pending.
// ----------------------------------------------------------------------------
module glyph_raster_checker
  import glyr_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  input  wire logic                   s_axis_tvalid,
  input  wire logic                   s_axis_tready,
  input  wire logic [BitsPerByte-1:0] s_axis_tdata,
  input  wire logic                   s_axis_tuser,

  input  wire logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  input  wire logic [OutDataW-1:0]    m_axis_tdata,
  input  wire logic                   m_axis_tlast,

  input  wire logic                   cfg_valid_i,
  input  wire logic                   cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [CfgDataW-1:0]    cfg_data_i,

  output int                          mismatches,
  output int                          outstanding,
  output int                          squares_seen
);

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] size;
    logic [ColorW-1:0] color;
    logic              last;
  } square_t;

  glyr_cfg_t         glyph_regs;
  logic [CoordW-1:0] col_ctr;
  logic [CoordW-1:0] row_ctr;
  square_t           squares_due[$];

  task automatic report(input string what, input int got, input int want);
    $display("%0t: square %0d %s: got 0x%0h, expected 0x%0h",
             $time, squares_seen, what, got, want);
    mismatches++;
  endtask

  // 8-bit arithmetic throughout, so every term wraps modulo 256
  function automatic logic [CoordW-1:0] glyph_top_row();
    logic [CoordW-1:0] top;
    top = glyph_regs.origin_y
        + glyph_regs.scale * (glyph_regs.line_advance - 8'd1)
        - 8'd2 * glyph_regs.scale
        + glyph_regs.scale * glyph_regs.glyph_y_offset;
    return top;
  endfunction

  task automatic raster_byte(input logic [BitsPerByte-1:0] bitmap, input logic glyph_first);
    logic [CoordW-1:0] top;
    square_t           sq;
    int                made;
    made = 0;
    if (glyph_first) begin
      col_ctr = '0;
      row_ctr = '0;
    end
    if (glyph_regs.glyph_width == '0 || glyph_regs.glyph_height == '0) return;
    top = glyph_top_row();
    for (int b = 0; b < BitsPerByte; b++) begin
      if (row_ctr >= glyph_regs.glyph_height) break;
      if (bitmap[BitsPerByte-1-b]) begin
        sq.x     = glyph_regs.origin_x + col_ctr * glyph_regs.scale;
        sq.y     = top + row_ctr * glyph_regs.scale;
        sq.size  = glyph_regs.scale;
        sq.color = glyph_regs.pixel_color;
        sq.last  = 1'b0;
        squares_due.push_back(sq);
        made++;
      end
      if ({1'b0, col_ctr} + 9'd1 >= {1'b0, glyph_regs.glyph_width}) begin
        col_ctr = '0;
        row_ctr = row_ctr + 8'd1;
      end else begin
        col_ctr = col_ctr + 8'd1;
      end
    end
    if (made > 0) begin
      sq = squares_due.pop_back();
      sq.last = 1'b1;
      squares_due.push_back(sq);
    end
  endtask

  task automatic check_square();
    square_t want;
    if (squares_due.size() == 0) begin
      report("arrived with nothing pending", m_axis_tdata[15:0], 0);
    end else begin
      want = squares_due.pop_front();
      if (m_axis_tdata[7:0] != want.x) report("x", m_axis_tdata[7:0], want.x);
      if (m_axis_tdata[15:8] != want.y) report("y", m_axis_tdata[15:8], want.y);
      if (m_axis_tdata[23:16] != want.size) report("size", m_axis_tdata[23:16], want.size);
      if (m_axis_tdata[39:24] != want.color) report("colour", m_axis_tdata[39:24], want.color);
      if (m_axis_tlast != want.last) report("last", m_axis_tlast, want.last);
    end
    squares_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_regs       = '0;
      glyph_regs.scale = 8'd1;
      col_ctr          = '0;
      row_ctr          = '0;
      squares_due.delete();
      mismatches       = 0;
      squares_seen     = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_square();
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          CfgOriginX:     glyph_regs.origin_x       = cfg_data_i[7:0];
          CfgOriginY:     glyph_regs.origin_y       = cfg_data_i[7:0];
          CfgGlyphWidth:  glyph_regs.glyph_width    = cfg_data_i[7:0];
          CfgGlyphHeight: glyph_regs.glyph_height   = cfg_data_i[7:0];
          CfgGlyphYOff:   glyph_regs.glyph_y_offset = cfg_data_i[7:0];
          CfgLineAdvance: glyph_regs.line_advance   = cfg_data_i[7:0];
          CfgScale:       glyph_regs.scale          = cfg_data_i[7:0];
          CfgPixelColor:  glyph_regs.pixel_color    = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) raster_byte(s_axis_tdata, s_axis_tuser);
    end
    outstanding = squares_due.size();
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for glyph_bitmap_rasterizer_core. A directed pass
// covers byte extremes, empty glyphs, bits past the glyph end, a width cut
// mid-glyph, zero scale and the largest glyph; random glyphs follow under random
// register settings with gaps on the bitmap side and stalls on the square side.
// ----------------------------------------------------------------------------
module testbench;
  import glyr_pkg::*;

  localparam int RandomItems = 420;
  localparam int SettleWait  = 16;
  localparam int CycleLimit  = 300000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [BitsPerByte-1:0] s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OutDataW-1:0]    m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIdxW-1:0]     cfg_index_i;
  logic [CfgDataW-1:0]    cfg_data_i;

  int mismatches;
  int outstanding;
  int squares_seen;

  int  cycles;
  int  beats_sent;
  int  live_items;
  int  glyph_count;
  int  reg_writes;
  bit  calm;
  bit  paused_once;

  glyph_bitmap_rasterizer_core dut (.*);
  glyph_raster_checker checker_i (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d squares pending", cycles, outstanding);
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 12);
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_byte(input logic [BitsPerByte-1:0] bitmap, input logic glyph_first);
    if (!calm && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bitmap;
    s_axis_tuser  <= glyph_first;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    beats_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (SettleWait) @(negedge clk_i);
  endtask

  task automatic reg_write(input cfg_reg_e idx, input logic [CfgDataW-1:0] value);
    logic [CfgDataW-1:0] word;
    word = value;
    if (idx != CfgPixelColor) word[15:8] = 8'($urandom);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= word;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    reg_writes++;
  endtask

  task automatic set_font(input logic [7:0] ox, input logic [7:0] oy, input logic [7:0] w,
                          input logic [7:0] h, input logic [7:0] yoff, input logic [7:0] adv,
                          input logic [7:0] sc, input logic [15:0] colour);
    reg_write(CfgOriginX, {8'h00, ox});
    reg_write(CfgOriginY, {8'h00, oy});
    reg_write(CfgGlyphWidth, {8'h00, w});
    reg_write(CfgGlyphHeight, {8'h00, h});
    reg_write(CfgGlyphYOff, {8'h00, yoff});
    reg_write(CfgLineAdvance, {8'h00, adv});
    reg_write(CfgScale, {8'h00, sc});
    reg_write(CfgPixelColor, colour);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] edgy_byte();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic random_glyph(input int w, input int h);
    int needed;
    int send_len;
    needed = (w == 0 || h == 0) ? 0 : (w * h + 7) / 8;
    if (needed == 0) begin
      send_len = $urandom_range(1, 2);
    end else begin
      send_len = (needed > 40) ? 40 : needed;
      if ($urandom_range(9) == 0) send_len = $urandom_range(1, send_len);
      else if (send_len == needed) send_len += $urandom_range(0, 1);
    end
    for (int k = 0; k < send_len; k++) begin
      if (k == send_len / 2 && send_len > 1 && (!paused_once || $urandom_range(7) == 0)) begin
        // hold the bitmap side until every square so far is out
        s_axis_tvalid <= 1'b0;
        do @(negedge clk_i); while (outstanding != 0);
        paused_once = 1'b1;
      end
      send_byte(8'($urandom),
                (k == 0) ? ($urandom_range(19) != 0) : ($urandom_range(49) == 0));
      if (k < needed) live_items++;
    end
    glyph_count++;
  endtask

  initial begin
    int w;
    int h;
    int r;
    int phase;
    logic [7:0] sc;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CfgOriginX;
    cfg_data_i    = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // 5x7 glyph near the right edge, negative offset; last byte lies past the end
    set_font(8'd250, 8'd3, 8'd5, 8'd7, 8'hFD, 8'd12, 8'd1, 16'hFFFF);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b0);
    settle();

    // empty glyphs: zero width, then zero height
    set_font(8'd0, 8'd0, 8'd0, 8'd7, 8'd0, 8'd0, 8'd2, 16'h1234);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    settle();
    set_font(8'd0, 8'd0, 8'd5, 8'd0, 8'd0, 8'd0, 8'd2, 16'h1234);
    send_byte(8'hFF, 1'b1);
    settle();

    // width cut below the column counter part way through a row
    set_font(8'd255, 8'd255, 8'd12, 8'd4, 8'h7F, 8'd0, 8'd255, 16'h0000);
    send_byte(8'hFF, 1'b1);
    settle();
    set_font(8'd255, 8'd255, 8'd3, 8'd4, 8'h7F, 8'd0, 8'd255, 16'h0000);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hC3, 1'b0);
    settle();

    // zero scale
    set_font(8'd17, 8'd40, 8'd3, 8'd3, 8'h80, 8'd255, 8'd0, 16'hA55A);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    settle();

    // largest glyph
    set_font(8'd128, 8'd200, 8'd255, 8'd255, 8'h80, 8'd255, 8'd2, 16'h5AA5);
    send_byte(8'h81, 1'b1);
    send_byte(8'h7E, 1'b0);
    settle();

    phase = 0;
    while (live_items < RandomItems) begin
      phase++;
      calm = (phase >= 6 && phase < 14);
      r = $urandom_range(99);
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 14);
      if (r < 3) w = 0;
      else if (r < 6) h = 0;
      else if (r < 9) w = 255;
      else if (r < 12) h = 255;
      r = $urandom_range(99);
      if (r < 10) sc = 8'd255;
      else if (r < 20) sc = 8'($urandom_range(1, 255));
      else sc = 8'($urandom_range(1, 6));
      set_font(edgy_byte(), edgy_byte(), 8'(w), 8'(h), 8'($urandom), edgy_byte(), sc,
               16'($urandom));
      repeat ($urandom_range(1, 3)) random_glyph(w, h);
      settle();
    end
    calm = 1'b0;

    $display("covered %0d bitmap beats over %0d random glyphs, %0d register writes",
             beats_sent, glyph_count, reg_writes);
    $display("%0d squares compared, %0d mismatches", squares_seen, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/glyr_pkg.sv
rtl/glyr_bit_walker.sv
rtl/glyr_square_emitter.sv
rtl/glyph_bitmap_rasterizer_core.sv
test/glyph_raster_checker.sv
test/testbench.sv
